>>> rtl/sdi_pkg.sv
// Shared types and codes for the SD card bring-up sequencer.
`default_nettype none

package sdi_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BLOCK_LENGTH  = 3'd0;
  localparam logic [2:0] REG_SETTLE_BASE   = 3'd1;
  localparam logic [2:0] REG_SETTLE_STEP   = 3'd2;
  localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd3;
  localparam logic [2:0] REG_MAX_POLLS     = 3'd4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [12:0] RST_BLOCK_LENGTH = 13'd512;
  localparam logic [15:0] RST_SETTLE_BASE  = 16'd10000;
  localparam logic [15:0] RST_SETTLE_STEP  = 16'd15000;
  localparam logic [2:0]  RST_MAX_ATTEMPTS = 3'd6;
  localparam logic [9:0]  RST_MAX_POLLS    = 10'd1000;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RESET    = 4'd1;
  localparam logic [3:0] PH_CLOCK    = 4'd2;
  localparam logic [3:0] PH_POWER    = 4'd3;
  localparam logic [3:0] PH_CMD0     = 4'd4;
  localparam logic [3:0] PH_IDLEWAIT = 4'd5;
  localparam logic [3:0] PH_CMD8     = 4'd6;
  localparam logic [3:0] PH_CMD55    = 4'd7;
  localparam logic [3:0] PH_ACMD41   = 4'd8;
  localparam logic [3:0] PH_POLLWAIT = 4'd9;
  localparam logic [3:0] PH_CMD2     = 4'd10;
  localparam logic [3:0] PH_CMD3     = 4'd11;
  localparam logic [3:0] PH_CMD7     = 4'd12;
  localparam logic [3:0] PH_CMD16    = 4'd13;
  localparam logic [3:0] PH_DONE     = 4'd14;
  localparam logic [3:0] PH_FAILED   = 4'd15;

  // Actions
  localparam logic [2:0] ACT_RESET  = 3'd0;
  localparam logic [2:0] ACT_CLOCK  = 3'd1;
  localparam logic [2:0] ACT_POWER  = 3'd2;
  localparam logic [2:0] ACT_DELAY  = 3'd3;
  localparam logic [2:0] ACT_CMD    = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;
  localparam logic [2:0] ACT_FAIL   = 3'd6;
  localparam logic [2:0] ACT_IGNORE = 3'd7;

  // Input kinds
  localparam logic EV_START    = 1'b0;
  localparam logic EV_COMPLETE = 1'b1;

  // Failure codes
  localparam logic [3:0] FC_NONE     = 4'd0;
  localparam logic [3:0] FC_RESET    = 4'd1;
  localparam logic [3:0] FC_CLOCK    = 4'd2;
  localparam logic [3:0] FC_IFCOND   = 4'd3;
  localparam logic [3:0] FC_ECHO     = 4'd4;
  localparam logic [3:0] FC_NOTREADY = 4'd5;
  localparam logic [3:0] FC_CID      = 4'd6;
  localparam logic [3:0] FC_RCA      = 4'd7;
  localparam logic [3:0] FC_SELECT   = 4'd8;
  localparam logic [3:0] FC_BLOCKLEN = 4'd9;

  // Command words and fixed arguments
  localparam logic [31:0] CW_CMD0      = 32'h0000_0000;
  localparam logic [31:0] CW_CMD8      = 32'h0802_0000;
  localparam logic [31:0] CW_CMD55     = 32'h3702_0000;
  localparam logic [31:0] CW_ACMD41    = 32'h2902_0000;
  localparam logic [31:0] CW_CMD2      = 32'h0201_0000;
  localparam logic [31:0] CW_CMD3      = 32'h0302_0000;
  localparam logic [31:0] CW_CMD7      = 32'h0703_0000;
  localparam logic [31:0] CW_CMD16     = 32'h1002_0000;
  localparam logic [31:0] CW_CLOCK_CTL = 32'h000E_0081;
  localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND  = 32'h40FF_8000;
  localparam logic [18:0] DLY_IDLE_US  = 19'd2000;
  localparam logic [18:0] DLY_POLL_US  = 19'd1000;

  typedef struct packed {
    logic [12:0] block_length;
    logic [15:0] settle_base_us;
    logic [15:0] settle_step_us;
    logic [2:0]  max_attempts;
    logic [9:0]  max_op_cond_polls;
  } sdi_cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  attempt_count;
    logic [9:0]  poll_count;
    logic [15:0] card_address;
    logic        card_ready;
    logic [3:0]  last_failure;
  } sdi_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] command_word;
    logic [31:0] argument;
    logic [18:0] delay_us;
    logic [2:0]  attempt_number;
    logic [3:0]  failure_code;
  } sdi_result_t;

endpackage

`default_nettype wire

>>> rtl/sdi_cfg_regs.sv
// Configuration register file of the SD card bring-up sequencer.
`default_nettype none

module sdi_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sdi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [sdi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sdi_pkg::sdi_cfg_t                   cfg
);
  import sdi_pkg::*;

  sdi_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_length      <= RST_BLOCK_LENGTH;
      cfg_r.settle_base_us    <= RST_SETTLE_BASE;
      cfg_r.settle_step_us    <= RST_SETTLE_STEP;
      cfg_r.max_attempts      <= RST_MAX_ATTEMPTS;
      cfg_r.max_op_cond_polls <= RST_MAX_POLLS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BLOCK_LENGTH: cfg_r.block_length      <= cfg_wdata[12:0];
        REG_SETTLE_BASE:  cfg_r.settle_base_us    <= cfg_wdata;
        REG_SETTLE_STEP:  cfg_r.settle_step_us    <= cfg_wdata;
        REG_MAX_ATTEMPTS: cfg_r.max_attempts      <= cfg_wdata[2:0];
        REG_MAX_POLLS:    cfg_r.max_op_cond_polls <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/sdi_step.sv
// Next-state and next-action logic for one sequencer event.
`default_nettype none

module sdi_step (
  input  wire logic          ev_cmd,
  input  wire logic          ev_ok,
  input  wire logic [31:0]   ev_resp,
  input  wire sdi_pkg::sdi_cfg_t   cfg,
  input  wire sdi_pkg::sdi_state_t st,
  output sdi_pkg::sdi_state_t st_nxt,
  output sdi_pkg::sdi_result_t res
);
  import sdi_pkg::*;

  logic [2:0]  fail_att;
  logic        fail_final;
  logic [9:0]  poll_inc;
  logic [18:0] settle_us;
  logic        do_fail;
  logic [3:0]  fail_code;
  logic        rdy_bit;

  assign fail_att   = st.attempt_count + 3'd1;
  // zero wrap counts as exhausted, which also makes a limit of 0 act as 1
  assign fail_final = (fail_att >= cfg.max_attempts) || (fail_att == 3'd0);
  assign poll_inc   = st.poll_count + 10'd1;
  assign settle_us  = 19'(cfg.settle_base_us)
                    + 19'(cfg.settle_step_us) * 19'(st.attempt_count);
  assign rdy_bit    = ev_resp[31];

  always_comb begin
    st_nxt           = st;
    res.action       = ACT_IGNORE;
    res.command_word = '0;
    res.argument     = '0;
    res.delay_us     = '0;
    do_fail          = 1'b0;
    fail_code        = FC_NONE;

    if (ev_cmd == EV_START) begin
      if (st.card_ready) begin
        res.action = ACT_DONE;
      end else if (st.phase inside {PH_IDLE, PH_DONE, PH_FAILED}) begin
        st_nxt.attempt_count = '0;
        st_nxt.last_failure  = FC_NONE;
        st_nxt.phase         = PH_RESET;
        st_nxt.poll_count    = '0;
        res.action           = ACT_RESET;
      end
    end else begin
      case (st.phase)
        PH_RESET: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_RESET;
          end else begin
            st_nxt.phase     = PH_CLOCK;
            res.action       = ACT_CLOCK;
            res.command_word = CW_CLOCK_CTL;
          end
        end
        PH_CLOCK: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_CLOCK;
          end else begin
            st_nxt.phase = PH_POWER;
            res.action   = ACT_POWER;
            res.delay_us = settle_us;
          end
        end
        PH_POWER: begin
          st_nxt.phase     = PH_CMD0;
          res.action       = ACT_CMD;
          res.command_word = CW_CMD0;
        end
        PH_CMD0: begin
          st_nxt.phase = PH_IDLEWAIT;
          res.action   = ACT_DELAY;
          res.delay_us = DLY_IDLE_US;
        end
        PH_IDLEWAIT: begin
          st_nxt.phase     = PH_CMD8;
          res.action       = ACT_CMD;
          res.command_word = CW_CMD8;
          res.argument     = ARG_IF_COND;
        end
        PH_CMD8: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_IFCOND;
          end else if (ev_resp != ARG_IF_COND) begin
            do_fail = 1'b1; fail_code = FC_ECHO;
          end else begin
            st_nxt.poll_count = '0;
            st_nxt.phase      = PH_CMD55;
            res.action        = ACT_CMD;
            res.command_word  = CW_CMD55;
          end
        end
        PH_CMD55: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_NOTREADY;
          end else begin
            st_nxt.phase     = PH_ACMD41;
            res.action       = ACT_CMD;
            res.command_word = CW_ACMD41;
            res.argument     = ARG_OP_COND;
          end
        end
        PH_ACMD41: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_NOTREADY;
          end else if (rdy_bit) begin
            st_nxt.phase     = PH_CMD2;
            res.action       = ACT_CMD;
            res.command_word = CW_CMD2;
          end else begin
            st_nxt.poll_count = poll_inc;
            if (poll_inc >= cfg.max_op_cond_polls || poll_inc == 10'd0) begin
              do_fail = 1'b1; fail_code = FC_NOTREADY;
            end else begin
              st_nxt.phase = PH_POLLWAIT;
              res.action   = ACT_DELAY;
              res.delay_us = DLY_POLL_US;
            end
          end
        end
        PH_POLLWAIT: begin
          st_nxt.phase     = PH_CMD55;
          res.action       = ACT_CMD;
          res.command_word = CW_CMD55;
        end
        PH_CMD2: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_CID;
          end else begin
            st_nxt.phase     = PH_CMD3;
            res.action       = ACT_CMD;
            res.command_word = CW_CMD3;
          end
        end
        PH_CMD3: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_RCA;
          end else begin
            st_nxt.card_address = ev_resp[31:16];
            st_nxt.phase        = PH_CMD7;
            res.action          = ACT_CMD;
            res.command_word    = CW_CMD7;
            res.argument        = {ev_resp[31:16], 16'h0000};
          end
        end
        PH_CMD7: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_SELECT;
          end else begin
            st_nxt.phase     = PH_CMD16;
            res.action       = ACT_CMD;
            res.command_word = CW_CMD16;
            res.argument     = 32'(cfg.block_length);
          end
        end
        PH_CMD16: begin
          if (!ev_ok) begin
            do_fail = 1'b1; fail_code = FC_BLOCKLEN;
          end else begin
            st_nxt.card_ready   = 1'b1;
            st_nxt.last_failure = FC_NONE;
            st_nxt.phase        = PH_DONE;
            res.action          = ACT_DONE;
          end
        end
        default: ;
      endcase
    end

    // common failure path: count the attempt, retry or give up
    if (do_fail) begin
      st_nxt.last_failure  = fail_code;
      st_nxt.attempt_count = fail_att;
      if (fail_final) begin
        st_nxt.phase = PH_FAILED;
        res.action   = ACT_FAIL;
      end else begin
        st_nxt.phase      = PH_RESET;
        st_nxt.poll_count = '0;
        res.action        = ACT_RESET;
      end
    end

    res.attempt_number = st_nxt.attempt_count;
    res.failure_code   = st_nxt.last_failure;
  end

endmodule

`default_nettype wire

>>> rtl/sd_card_init_sequencer_unit.sv
// Top level of the SD card bring-up sequencer.
`default_nettype none

// Channel   Dir  Payload                                             Handshake
// in_       in   tuser: cmd; tdata: ok, response (+7 pad bits)       tvalid/tready
// out_      out  tuser: action; tdata: command_word, argument,
//                delay_us, attempt_number, failure_code (+6 pad)     tvalid/tready
// cfg_      in   cfg_addr selects register, cfg_wdata                cfg_we, no wait
//
// One event in, one action out. An event is held in an input register,
// then the phase logic writes the result register and the sequencer state
// on the same edge. A new transaction is taken every cycle; throughput is
// set only by the output side. A stalled result holds the result register
// and the input register, so nothing is dropped. Reset (synchronous) puts
// the sequencer idle and loads register defaults; there is no clearing pass.

module sd_card_init_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // event input
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [39:0]                    in_tdata,   // [0] ok, [32:1] response
  input  wire logic                           in_tuser,   // [0] cmd
  // action output
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [95:0]                         out_tdata,  // [31:0] command_word,
                                                          // [63:32] argument,
                                                          // [82:64] delay_us,
                                                          // [85:83] attempt_number,
                                                          // [89:86] failure_code
  output logic [2:0]                          out_tuser,  // [2:0] action
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [sdi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [sdi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sdi_pkg::*;

  sdi_cfg_t    cfg;
  sdi_state_t  st_r, st_nxt;
  sdi_result_t res, res_r;

  // input register
  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic        s1_ok_r;
  logic [31:0] s1_resp_r;
  logic        s1_adv;

  // result register
  logic        out_valid_r;

  sdi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdi_step u_step (
    .ev_cmd  (s1_cmd_r),
    .ev_ok   (s1_ok_r),
    .ev_resp (s1_resp_r),
    .cfg     (cfg),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // the held event moves on when the result slot is free or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_ok_r   <= in_tdata[0];
      s1_resp_r <= in_tdata[32:1];
    end
  end

  // sequencer state commits together with the result it produced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_IDLE;
      st_r.attempt_count <= '0;
      st_r.poll_count    <= '0;
      st_r.card_address  <= '0;
      st_r.card_ready    <= 1'b0;
      st_r.last_failure  <= FC_NONE;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {6'b0, res_r.failure_code, res_r.attempt_number,
                       res_r.delay_us, res_r.argument, res_r.command_word};

  // --- checks ---
  a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.action == ACT_FAIL) |-> (res_r.failure_code != FC_NONE))
    else $error("failed action without a failure code");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.action == ACT_DONE) |-> (res_r.failure_code == FC_NONE))
    else $error("done action with a stale failure code");

  a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.card_ready |-> (st_r.phase == PH_DONE))
    else $error("card ready outside the done phase");

  a_hold_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_resp_r) && $stable(s1_cmd_r)))
    else $error("held event lost while result stalled");

endmodule

`default_nettype wire

>>> bench/sd_card_init_sequencer_unit_tb.sv
// Testbench for the SD card bring-up sequencer: event stimulus, action prediction, checks.
`timescale 1ns / 100ps

module sd_card_init_sequencer_unit_tb;
  import sdi_pkg::*;

  // Run length and guard time
  localparam int EVENT_TARGET = 1600;     // non-ignored events before the final bring-up
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int SETTLE_CYC   = 4;        // input and result registers plus margin
  localparam int HOLD_CYC     = 80;       // long receiver hold-off for the pressure test

  // Receiver stall patterns
  localparam int RX_STEADY   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_SPARSE   = 3;

  // Every input is known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata  = '0;   // [0] ok, [32:1] response
  logic        in_tuser  = 1'b0; // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;        // [31:0] command_word, [63:32] argument,
                                 // [82:64] delay_us, [85:83] attempt_number,
                                 // [89:86] failure_code
  logic [2:0]  out_tuser;        // [2:0] action
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the sequencer: registers and state
  sdi_cfg_t   cfg_mirror;
  sdi_state_t seq;

  // Actions still owed by the block, oldest first
  sdi_result_t expected_actions[$];

  int err_count    = 0;
  int events_sent  = 0;   // accepted events that were not ignored
  int burst_left   = 0;
  int hold_request = 0;   // set by a test, picked up by the receiver
  int hold_left    = 0;
  int rx_cycle     = 0;
  int rx_mode      = RX_STEADY;

  sd_card_init_sequencer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Action predictor
  // ---------------------------------------------------------------------------

  // Failed step: record the code, count the attempt, then retry or give up.
  // Attempt counter wraps at 3 bits; a wrap to zero also gives up.
  task automatic note_failure(input logic [3:0] code, inout sdi_result_t act);
    seq.last_failure  = code;
    seq.attempt_count = seq.attempt_count + 3'd1;
    if (seq.attempt_count >= cfg_mirror.max_attempts || seq.attempt_count == 3'd0) begin
      seq.phase  = PH_FAILED;
      act.action = ACT_FAIL;
    end else begin
      seq.phase      = PH_RESET;
      seq.poll_count = '0;
      act.action     = ACT_RESET;
    end
  endtask

  task automatic issue_command(input logic [3:0] next_phase, input logic [31:0] cw,
                               input logic [31:0] arg, inout sdi_result_t act);
    seq.phase        = next_phase;
    act.action       = ACT_CMD;
    act.command_word = cw;
    act.argument     = arg;
  endtask

  // Work out the action that one accepted event causes and queue it
  task automatic predict_next_action(input logic kind, input logic ok, input logic [31:0] resp);
    sdi_result_t act;
    act        = '0;
    act.action = ACT_IGNORE;
    if (kind == EV_START) begin
      if (seq.card_ready) begin
        act.action = ACT_DONE;
      end else if (seq.phase == PH_IDLE || seq.phase == PH_DONE || seq.phase == PH_FAILED) begin
        // fresh bring-up
        seq.attempt_count = '0;
        seq.last_failure  = FC_NONE;
        seq.phase         = PH_RESET;
        seq.poll_count    = '0;
        act.action        = ACT_RESET;
      end
    end else begin
      case (seq.phase)
        PH_RESET: begin
          if (!ok) note_failure(FC_RESET, act);
          else begin
            seq.phase        = PH_CLOCK;
            act.action       = ACT_CLOCK;
            act.command_word = CW_CLOCK_CTL;
          end
        end
        PH_CLOCK: begin
          if (!ok) note_failure(FC_CLOCK, act);
          else begin
            // settle time grows with each retry
            seq.phase    = PH_POWER;
            act.action   = ACT_POWER;
            act.delay_us = {3'b0, cfg_mirror.settle_base_us}
                         + {16'b0, seq.attempt_count} * {3'b0, cfg_mirror.settle_step_us};
          end
        end
        PH_POWER:    issue_command(PH_CMD0, CW_CMD0, '0, act);
        PH_CMD0: begin
          // CMD0 has no response: ok and response are not looked at
          seq.phase    = PH_IDLEWAIT;
          act.action   = ACT_DELAY;
          act.delay_us = DLY_IDLE_US;
        end
        PH_IDLEWAIT: issue_command(PH_CMD8, CW_CMD8, ARG_IF_COND, act);
        PH_CMD8: begin
          if (!ok) note_failure(FC_IFCOND, act);
          else if (resp != ARG_IF_COND) note_failure(FC_ECHO, act);
          else begin
            seq.poll_count = '0;
            issue_command(PH_CMD55, CW_CMD55, '0, act);
          end
        end
        PH_CMD55: begin
          if (!ok) note_failure(FC_NOTREADY, act);
          else issue_command(PH_ACMD41, CW_ACMD41, ARG_OP_COND, act);
        end
        PH_ACMD41: begin
          if (!ok) note_failure(FC_NOTREADY, act);
          else if (resp[31]) issue_command(PH_CMD2, CW_CMD2, '0, act);
          else begin
            // card busy: poll again unless the budget is spent (zero budget acts as one)
            seq.poll_count = seq.poll_count + 10'd1;
            if (seq.poll_count >= cfg_mirror.max_op_cond_polls || seq.poll_count == '0) begin
              note_failure(FC_NOTREADY, act);
            end else begin
              seq.phase    = PH_POLLWAIT;
              act.action   = ACT_DELAY;
              act.delay_us = DLY_POLL_US;
            end
          end
        end
        PH_POLLWAIT: issue_command(PH_CMD55, CW_CMD55, '0, act);
        PH_CMD2: begin
          if (!ok) note_failure(FC_CID, act);
          else issue_command(PH_CMD3, CW_CMD3, '0, act);
        end
        PH_CMD3: begin
          if (!ok) note_failure(FC_RCA, act);
          else begin
            // relative card address sits in the upper response half
            seq.card_address = resp[31:16];
            issue_command(PH_CMD7, CW_CMD7, {resp[31:16], 16'h0000}, act);
          end
        end
        PH_CMD7: begin
          if (!ok) note_failure(FC_SELECT, act);
          else issue_command(PH_CMD16, CW_CMD16, {19'b0, cfg_mirror.block_length}, act);
        end
        PH_CMD16: begin
          if (!ok) note_failure(FC_BLOCKLEN, act);
          else begin
            seq.card_ready   = 1'b1;
            seq.last_failure = FC_NONE;
            seq.phase        = PH_DONE;
            act.action       = ACT_DONE;
          end
        end
        default: ;  // idle, done, failed: completion ignored
      endcase
    end
    act.attempt_number = seq.attempt_count;
    act.failure_code   = seq.last_failure;
    expected_actions.push_back(act);
    if (act.action != ACT_IGNORE) events_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver side: events and register writes, always entered at a falling edge
  // ---------------------------------------------------------------------------

  // One event transaction. Bursts of random length with random gaps between.
  task automatic send_event(input logic kind, input logic ok, input logic [31:0] resp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, resp, ok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_next_action(kind, ok, resp);
    burst_left--;
    @(negedge clk);
  endtask

  // Quiet the input and let every owed action come out before touching registers
  task automatic drain_actions();
    in_tvalid <= 1'b0;
    while (expected_actions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_BLOCK_LENGTH: cfg_mirror.block_length      = val[12:0];
      REG_SETTLE_BASE:  cfg_mirror.settle_base_us    = val;
      REG_SETTLE_STEP:  cfg_mirror.settle_step_us    = val;
      REG_MAX_ATTEMPTS: cfg_mirror.max_attempts      = val[2:0];
      REG_MAX_POLLS:    cfg_mirror.max_op_cond_polls = val[9:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [12:0] blen, input logic [15:0] base,
                                input logic [15:0] step, input logic [2:0] tries,
                                input logic [9:0] polls);
    write_reg(REG_BLOCK_LENGTH, {3'b0, blen});
    write_reg(REG_SETTLE_BASE, base);
    write_reg(REG_SETTLE_STEP, step);
    write_reg(REG_MAX_ATTEMPTS, {13'b0, tries});
    write_reg(REG_MAX_POLLS, {6'b0, polls});
  endtask

  // Play the card through one bring-up. Each step answers what the sequencer
  // is waiting for. A normal session never lets CMD16 pass, so the card stays
  // unready and the deep states stay reachable; a clean session ends in done.
  task automatic run_session(input bit clean);
    int          fail_pct;
    int          ready_pct;
    logic        ok;
    logic [31:0] resp;
    fail_pct  = clean ? 0 : $urandom_range(1, 12);
    ready_pct = $urandom_range(15, 60);
    send_event(EV_START, 1'($urandom_range(0, 1)), $urandom);
    while (seq.phase != PH_FAILED && seq.phase != PH_DONE) begin
      if (!clean && $urandom_range(0, 99) < 3) begin
        // stray start while busy
        send_event(EV_START, 1'($urandom_range(0, 1)), $urandom);
        continue;
      end
      ok   = ($urandom_range(0, 99) >= fail_pct);
      resp = $urandom;
      case (seq.phase)
        PH_CMD8: begin
          if (clean || $urandom_range(0, 9) < 8) resp = ARG_IF_COND;
          else if ($urandom_range(0, 1) == 0) resp = ARG_IF_COND ^ (32'h1 << $urandom_range(0, 31));
        end
        PH_ACMD41: resp[31] = ($urandom_range(0, 99) < ready_pct);
        PH_CMD16:  ok = clean;
        default: ;
      endcase
      send_event(EV_COMPLETE, ok, resp);
    end
    // completion with nothing outstanding
    if (!clean && $urandom_range(0, 2) == 0)
      send_event(EV_COMPLETE, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the whole command order at reset settings, then a few early failures
  task automatic test_directed_walk();
    send_event(EV_COMPLETE, 1'b1, 32'hFFFF_FFFF); // idle: ignored
    send_event(EV_START, 1'b0, 32'h0000_0000);    // host reset, attempt 0
    send_event(EV_START, 1'b1, 32'hFFFF_FFFF);    // busy: ignored
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // clock start
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // power, base settle
    send_event(EV_COMPLETE, 1'b0, 32'hFFFF_FFFF); // delay done, ok not looked at -> CMD0
    send_event(EV_COMPLETE, 1'b0, 32'h0);         // CMD0 has no response -> idle delay
    send_event(EV_COMPLETE, 1'b0, 32'h5555_5555); // -> CMD8
    send_event(EV_COMPLETE, 1'b1, ARG_IF_COND);   // echo good -> CMD55
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // -> ACMD41
    send_event(EV_COMPLETE, 1'b1, 32'h7FFF_FFFF); // busy -> poll delay
    send_event(EV_COMPLETE, 1'b0, 32'h0);         // -> CMD55
    send_event(EV_COMPLETE, 1'b1, 32'hFFFF_FFFF); // -> ACMD41
    send_event(EV_COMPLETE, 1'b1, 32'h8000_0000); // ready -> CMD2
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // -> CMD3
    send_event(EV_COMPLETE, 1'b1, 32'hA5C3_FFFF); // address latched -> CMD7
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // -> CMD16, reset block length
    send_event(EV_COMPLETE, 1'b0, 32'h0);         // block length fails -> attempt 1
    send_event(EV_COMPLETE, 1'b0, 32'h0);         // host reset fails -> attempt 2
    send_event(EV_COMPLETE, 1'b1, 32'h0);         // clock start
    send_event(EV_COMPLETE, 1'b0, 32'h0);         // clock fails -> attempt 3
    run_session(1'b0);                            // play out to failed
  endtask

  // All registers zero: one attempt only, one poll only, zero block length
  task automatic test_zero_registers();
    drain_actions();
    write_all_regs('0, '0, '0, '0, '0);
    run_session(1'b0);
    run_session(1'b0);
  endtask

  // Receiver holds off while events keep coming, so the input stalls
  task automatic test_backpressure();
    drain_actions();
    write_all_regs(13'd512, 16'd100, 16'd200, 3'd7, 10'd6);
    hold_request = HOLD_CYC;
    run_session(1'b0);
  endtask

  // Random register settings, each followed by a few sessions
  task automatic test_random_sessions();
    logic [12:0] blen;
    logic [15:0] base;
    logic [15:0] step;
    logic [9:0]  polls;
    int          n_sess;
    while (events_sent < EVENT_TARGET) begin
      drain_actions();
      case ($urandom_range(0, 4))
        0:       blen = 13'd0;
        1:       blen = 13'd1;
        2:       blen = 13'd4096;
        3:       blen = 13'h1FFF;
        default: blen = 13'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       base = 16'd0;
        1:       base = 16'hFFFF;
        default: base = 16'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       step = 16'd0;
        1:       step = 16'hFFFF;
        default: step = 16'($urandom);
      endcase
      // mostly tight poll budgets so that running out is common
      polls = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(9, 1023))
                                          : 10'($urandom_range(0, 8));
      write_all_regs(blen, base, step, 3'($urandom_range(0, 7)), polls);
      n_sess = $urandom_range(1, 3);
      repeat (n_sess) run_session(1'b0);
    end
  endtask

  // Widest settle, attempt and poll settings, a clean bring-up to done, then the card stays ready
  task automatic test_final_bringup();
    drain_actions();
    write_all_regs(13'd4096, 16'hFFFF, 16'hFFFF, 3'd7, 10'd1023);
    run_session(1'b1);
    send_event(EV_START, 1'b1, $urandom);    // ready: done again
    send_event(EV_COMPLETE, 1'b1, $urandom); // nothing outstanding: ignored
    send_event(EV_START, 1'b0, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    cfg_mirror.block_length      = RST_BLOCK_LENGTH;
    cfg_mirror.settle_base_us    = RST_SETTLE_BASE;
    cfg_mirror.settle_step_us    = RST_SETTLE_STEP;
    cfg_mirror.max_attempts      = RST_MAX_ATTEMPTS;
    cfg_mirror.max_op_cond_polls = RST_MAX_POLLS;
    seq       = '0;
    seq.phase = PH_IDLE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_walk();
    test_zero_registers();
    test_backpressure();
    test_random_sessions();
    test_final_bringup();

    in_tvalid <= 1'b0;
    while (expected_actions.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYC) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, switched to a random one periodically, plus the
  // long hold-off asked for by the pressure test
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(RX_STEADY, RX_SPARSE);
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY:   out_tready <= 1'b1;
        RX_RANDOM:   out_tready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: out_tready <= (rx_cycle % 3 == 0);
        default:     out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each action transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    sdi_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_actions.size() == 0) begin
        $error("action transaction with nothing expected: action 0x%0h", out_tuser);
        err_count++;
      end else begin
        want = expected_actions.pop_front();
        check_field("action",         want.action,         out_tuser);
        check_field("command_word",   want.command_word,   out_tdata[31:0]);
        check_field("argument",       want.argument,       out_tdata[63:32]);
        check_field("delay_us",       want.delay_us,       out_tdata[82:64]);
        check_field("attempt_number", want.attempt_number, out_tdata[85:83]);
        check_field("failure_code",   want.failure_code,   out_tdata[89:86]);
      end
    end
  end

endmodule

>>> sim.f
rtl/sdi_pkg.sv
rtl/sdi_cfg_regs.sv
rtl/sdi_step.sv
rtl/sd_card_init_sequencer_unit.sv
bench/sd_card_init_sequencer_unit_tb.sv
